/* rtl/core/uapw_pkg.sv */
`default_nettype none

package uapw_pkg;

    // Walk phase: which level's entry the walk is waiting for
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_L4   = 3'd1,
        PH_L3   = 3'd2,
        PH_L2   = 3'd3,
        PH_L1   = 3'd4
    } t_phase;

    // Input tuser codes
    localparam logic MODE_REQ = 1'b0;
    localparam logic MODE_RSP = 1'b1;

    // Output tuser codes
    localparam logic KIND_READ    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WBASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WTOP  = 2'd2;

    // Entry flag bit positions
    localparam int unsigned BIT_P  = 0;
    localparam int unsigned BIT_U  = 2;
    localparam int unsigned BIT_PS = 7;

    localparam int unsigned PA_W    = 52;  // physical address
    localparam int unsigned VA_W    = 48;  // user window address space
    localparam int unsigned PG_OFS  = 12;  // 4 KiB pages
    localparam int unsigned TBL_W   = PA_W - PG_OFS;  // table frame number
    localparam int unsigned VPN_W   = VA_W - PG_OFS;  // virtual page number
    localparam int unsigned IDX_W   = 9;   // 512 entries per table

    typedef struct packed {
        logic [TBL_W-1:0] root_frame;
        logic [VA_W-1:0]  win_base;
        logic [VA_W-1:0]  win_top;
    } t_cfg;

    typedef struct packed {
        t_phase           phase;
        logic [VPN_W-1:0] cursor_pg;   // page under check
        logic [VA_W-1:0]  range_end;   // first byte past the range
    } t_walk_state;

    typedef struct packed {
        logic            valid;
        logic            kind;
        logic [PA_W-1:0] addr;
        logic            ok;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/uapw_step.sv */
`default_nettype none

module uapw_step (
    input  wire  uapw_pkg::t_cfg        i_cfg,
    input  wire  uapw_pkg::t_walk_state i_state,
    input  wire                         i_mode,
    input  wire  [63:0]                 i_virt_addr,
    input  wire  [63:0]                 i_range_length,
    input  wire  [63:0]                 i_entry_data,
    output uapw_pkg::t_walk_state       o_state,
    output uapw_pkg::t_result           o_result
);
    import uapw_pkg::*;

    function automatic t_result read_req(input logic [TBL_W-1:0] frame,
                                         input logic [IDX_W-1:0] idx);
        t_result r;
        r.valid = 1'b1;
        r.kind  = KIND_READ;
        r.addr  = {frame, idx, 3'b000};
        r.ok    = 1'b0;
        return r;
    endfunction

    function automatic t_result verdict(input logic ok);
        t_result r;
        r.valid = 1'b1;
        r.kind  = KIND_VERDICT;
        r.addr  = '0;
        r.ok    = ok;
        return r;
    endfunction

    logic             va_hi_set;
    logic             len_hi_set;
    logic             out_of_window;
    logic [VA_W-1:0]  room;
    logic [VPN_W:0]   next_pg;
    logic             more_pages;

    // Window test: va in [base, top) and len <= top - va
    assign va_hi_set  = |i_virt_addr[63:VA_W];
    assign len_hi_set = |i_range_length[63:VA_W];
    assign room       = i_cfg.win_top - i_virt_addr[VA_W-1:0];
    assign out_of_window = (!va_hi_set && (i_virt_addr[VA_W-1:0] < i_cfg.win_base))
                         || va_hi_set
                         || (i_virt_addr[VA_W-1:0] >= i_cfg.win_top)
                         || len_hi_set
                         || (i_range_length[VA_W-1:0] > room);

    assign next_pg    = {1'b0, i_state.cursor_pg} + {{VPN_W{1'b0}}, 1'b1};
    assign more_pages = {next_pg, {PG_OFS{1'b0}}} < {1'b0, i_state.range_end};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_mode == MODE_REQ) begin
            if (i_state.phase == PH_IDLE) begin
                if (i_range_length == '0) begin
                    o_result = verdict(1'b1);
                end else if (out_of_window) begin
                    o_result = verdict(1'b0);
                end else begin
                    o_state.cursor_pg = i_virt_addr[VA_W-1:PG_OFS];
                    o_state.range_end = i_virt_addr[VA_W-1:0] + i_range_length[VA_W-1:0];
                    o_state.phase     = PH_L4;
                    o_result = read_req(i_cfg.root_frame, i_virt_addr[47:39]);
                end
            end
        end else begin
            unique case (i_state.phase)
                PH_L4: begin
                    if (i_entry_data[PA_W-1:PG_OFS] == '0) begin
                        o_state.phase = PH_IDLE;
                        o_result      = verdict(1'b0);
                    end else begin
                        o_state.phase = PH_L3;
                        o_result = read_req(i_entry_data[PA_W-1:PG_OFS],
                                            i_state.cursor_pg[26:18]);
                    end
                end
                PH_L3: begin
                    if (!i_entry_data[BIT_P]) begin
                        o_state.phase = PH_IDLE;
                        o_result      = verdict(1'b0);
                    end else begin
                        o_state.phase = PH_L2;
                        o_result = read_req(i_entry_data[PA_W-1:PG_OFS],
                                            i_state.cursor_pg[17:9]);
                    end
                end
                PH_L2: begin
                    if (!i_entry_data[BIT_P] || i_entry_data[BIT_PS]) begin
                        o_state.phase = PH_IDLE;
                        o_result      = verdict(1'b0);
                    end else begin
                        o_state.phase = PH_L1;
                        o_result = read_req(i_entry_data[PA_W-1:PG_OFS],
                                            i_state.cursor_pg[8:0]);
                    end
                end
                PH_L1: begin
                    if (!i_entry_data[BIT_P] || !i_entry_data[BIT_U]) begin
                        o_state.phase = PH_IDLE;
                        o_result      = verdict(1'b0);
                    end else begin
                        o_state.cursor_pg = next_pg[VPN_W-1:0];
                        if (more_pages) begin
                            o_state.phase = PH_L4;
                            o_result = read_req(i_cfg.root_frame, next_pg[35:27]);
                        end else begin
                            o_state.phase = PH_IDLE;
                            o_result      = verdict(1'b1);
                        end
                    end
                end
                default: begin
                    // stray response while idle: dropped
                    o_state.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/user_access_page_walk_check.sv */
`default_nettype none
// Channel    | Dir | Handshake                     | Payload
// -----------+-----+-------------------------------+------------------------------------------
// s_axis     | in  | s_axis_tvalid / s_axis_tready | tuser: mode; tdata: va, length, entry
// m_axis     | out | m_axis_tvalid / m_axis_tready | tuser: result kind; tdata: addr, ok
// cfg write  | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One request per cycle while the output register is not stalled: each request is
// decoded in the cycle it is taken and its result lands in the output register on that edge.
// The output register is the only stall point: a new request is taken whenever
// it is empty or being drained in the same cycle.
// Reset (synchronous, active low) returns the walk to idle, empties the output
// register and clears the configuration registers. Config writes are always taken.

module user_access_page_walk_check (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // request stream
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [191:0] s_axis_tdata,   // [63:0] virt_addr, [127:64] range_length,
                                         // [191:128] entry_data
    input  wire          s_axis_tuser,   // [0] mode (0 check, 1 entry response)
    // result stream
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [55:0]  m_axis_tdata,   // [51:0] read_address, [52] access_ok, zero pad
    output logic         m_axis_tuser,   // [0] result_kind (0 read, 1 verdict)
    // configuration writes
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [uapw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [uapw_pkg::PA_W-1:0]      i_cfg_data
);
    import uapw_pkg::*;

    // configuration
    t_cfg r_cfg;

    // walk state
    t_phase           r_phase;
    logic [VPN_W-1:0] r_cursor_pg;
    logic [VA_W-1:0]  r_range_end;

    // output register
    logic             r_out_valid;
    logic             r_out_kind;
    logic [PA_W-1:0]  r_out_addr;
    logic             r_out_ok;

    t_walk_state cur_state;
    t_walk_state n_state;
    t_result     n_result;
    logic        req_take;

    assign cur_state.phase     = r_phase;
    assign cur_state.cursor_pg = r_cursor_pg;
    assign cur_state.range_end = r_range_end;

    uapw_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (cur_state),
        .i_mode         (s_axis_tuser),
        .i_virt_addr    (s_axis_tdata[63:0]),
        .i_range_length (s_axis_tdata[127:64]),
        .i_entry_data   (s_axis_tdata[191:128]),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // take a request when the output slot is free or draining this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign req_take      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROOT:  r_cfg.root_frame <= i_cfg_data[PA_W-1:PG_OFS];
                CFG_WBASE: r_cfg.win_base   <= i_cfg_data[VA_W-1:0];
                CFG_WTOP:  r_cfg.win_top    <= i_cfg_data[VA_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else if (req_take) begin
            r_phase     <= n_state.phase;
            r_out_valid <= n_result.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_cursor_pg <= n_state.cursor_pg;
            r_range_end <= n_state.range_end;
            if (n_result.valid) begin
                r_out_kind <= n_result.kind;
                r_out_addr <= n_result.addr;
                r_out_ok   <= n_result.ok;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {3'b000, r_out_ok, r_out_addr};

`ifndef SYNTHESIS
    // a pending read request always means a walk is in flight
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_READ) |-> (r_phase != PH_IDLE))
        else $error("read request pending while walk idle");

    // a pending verdict always means the walk has ended
    a_verdict_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_VERDICT) |-> (r_phase == PH_IDLE))
        else $error("verdict pending while walk busy");

    // a read request never carries a pass flag
    a_read_no_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_READ) |-> !r_out_ok)
        else $error("read request with access_ok set");

    // held result blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while result stalled");
`endif

endmodule

`default_nettype wire
